### rtl/core/harmonic_comb_energy_macros.svh
// Assertion macros used by the harmonic comb energy port checker.
`ifndef HARMONIC_COMB_ENERGY_MACROS_SVH
`define HARMONIC_COMB_ENERGY_MACROS_SVH

// Implication checked in the same cycle, disabled while reset is asserted.
`define HCE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hce assertion failed");

// Implication checked in the next cycle, active during reset too.
`define HCE_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("hce assertion failed");

`endif

### rtl/core/hce_pkg.sv
// Package with widths, defaults and register codes of the harmonic comb energy block.
package hce_pkg;

    localparam int FREQ_W            = 23;
    localparam int BINW_W            = 24;
    localparam int MAG_W             = 24;
    localparam int ENERGY_W          = 35;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_DATA_W        = 24;
    localparam int S_TDATA_W         = 24;
    localparam int M_TDATA_W         = 40;
    localparam int DEF_NUM_HARMONICS = 30;
    localparam int DEF_MAX_BINS      = 2048;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FUND = 1'b0,
        CFG_BINW = 1'b1
    } t_cfg_idx;

endpackage

### rtl/core/hce_match.sv
// Parallel harmonic window test of one bin against all harmonic multiples.
module hce_match #(
    parameter int NUM_HARMONICS = hce_pkg::DEF_NUM_HARMONICS,
    parameter int HW            = 29,
    parameter int CW            = 36
) (
    input  logic [HW-1:0]                 i_harm [NUM_HARMONICS],
    input  logic [CW-1:0]                 i_c2,
    input  logic [hce_pkg::BINW_W-1:0]    i_bw,
    output logic                          o_sel
);

    localparam int CMPW = ((CW > HW) ? CW : HW) + 1;

    logic [CMPW-1:0]          c2_ext;
    logic [CMPW-1:0]          hi_edge;
    logic [NUM_HARMONICS-1:0] hit;

    // Upper edge of the doubled-scale window, shared by all harmonics
    assign c2_ext  = CMPW'(i_c2);
    assign hi_edge = c2_ext + CMPW'(i_bw);

    // One window test per harmonic: 2hf + bw >= 2kbw and 2hf <= 2kbw + bw
    always_comb begin
        for (int h = 0; h < NUM_HARMONICS; h++) begin
            hit[h] = ((CMPW'(i_harm[h]) + CMPW'(i_bw)) >= c2_ext) &&
                     (CMPW'(i_harm[h]) <= hi_edge);
        end
    end

    assign o_sel = |hit;

endmodule

### rtl/core/harmonic_comb_energy.sv
// Top level of the harmonic comb energy block: bin counter, pipeline and accumulator.
// A last bin passes capture, multiply, compare and output registers to show on o_m_tvalid.
// Throughput: one bin per cycle; the multiply stage (k * bin width) and the
// parallel harmonic compare stage are each one register deep.
// Input stalls only while a last bin waits behind an output item not yet taken.
// Synchronous active-low reset clears configuration, counter, running sum and valids.
module harmonic_comb_energy #(
    parameter int NUM_HARMONICS = hce_pkg::DEF_NUM_HARMONICS,
    parameter int MAX_BINS      = hce_pkg::DEF_MAX_BINS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // bin input
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [hce_pkg::S_TDATA_W-1:0]     i_s_tdata,   // [23:0] magnitude
    input  logic                              i_s_tlast,   // last_bin
    // energy output
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [hce_pkg::M_TDATA_W-1:0]     o_m_tdata,   // [34:0] energy, [39:35] zero
    // configuration write
    input  logic                              i_cfg_we,
    input  logic [hce_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [hce_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int KW = (MAX_BINS > 2) ? $clog2(MAX_BINS) : 1;
    localparam int HW = hce_pkg::FREQ_W + 1 + $clog2(NUM_HARMONICS + 1);
    localparam int CW = hce_pkg::BINW_W + KW + 1;
    localparam int PW = hce_pkg::BINW_W + KW;
    localparam int EW = hce_pkg::ENERGY_W;
    localparam int MW = hce_pkg::MAG_W;
    localparam logic [KW-1:0] CNT_MAX = KW'(MAX_BINS - 1);

    // configuration state
    logic [HW-1:0]                r_harm [NUM_HARMONICS];
    logic [hce_pkg::BINW_W-1:0]   r_bw;

    // bin counter and pipeline
    logic [KW-1:0]  r_bin_cnt;
    logic           r_v1, r_v2, r_v3;
    logic [KW-1:0]  r_k1;
    logic [MW-1:0]  r_mag1, r_mag2, r_mag3;
    logic           r_last1, r_last2, r_last3;
    logic [CW-1:0]  r_c2;
    logic           r_sel3;
    logic           n_sel;

    // accumulator and output register
    logic [EW-1:0]  r_sum;
    logic [EW-1:0]  n_sum;
    logic [EW:0]    sum_wide;
    logic [EW-1:0]  r_out_data;
    logic           r_out_valid;

    logic           advance;
    logic           s_acc;

    // Freeze only when a last bin must enter a full output register
    assign advance    = !(r_v3 && r_last3 && r_out_valid && !i_m_tready);
    assign o_s_tready = advance;
    assign s_acc      = i_s_tvalid && advance;

    // Configuration writes; harmonic multiples 2*h*f kept ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bw <= '0;
            for (int h = 0; h < NUM_HARMONICS; h++) begin
                r_harm[h] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == hce_pkg::CFG_FUND) begin
                for (int h = 0; h < NUM_HARMONICS; h++) begin
                    r_harm[h] <= HW'((HW'(h + 1) *
                                      HW'(i_cfg_data[hce_pkg::FREQ_W-1:0])) << 1);
                end
            end else if (i_cfg_idx == hce_pkg::CFG_BINW) begin
                r_bw <= i_cfg_data[hce_pkg::BINW_W-1:0];
            end
        end
    end

    // Bin counter: saturates, clears after a last bin
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_cnt <= '0;
        end else if (s_acc) begin
            if (i_s_tlast) begin
                r_bin_cnt <= '0;
            end else if (r_bin_cnt < CNT_MAX) begin
                r_bin_cnt <= r_bin_cnt + 1'b1;
            end
        end
    end

    // Pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (advance) begin
            r_v1 <= s_acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Harmonic window test on the doubled bin center
    hce_match #(
        .NUM_HARMONICS (NUM_HARMONICS),
        .HW            (HW),
        .CW            (CW)
    ) u_match (
        .i_harm (r_harm),
        .i_c2   (r_c2),
        .i_bw   (r_bw),
        .o_sel  (n_sel)
    );

    // Pipeline payload: capture, center multiply, window test
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_k1    <= r_bin_cnt;
            r_mag1  <= i_s_tdata[MW-1:0];
            r_last1 <= i_s_tlast;
            r_c2    <= {PW'(PW'(r_k1) * PW'(r_bw)), 1'b0};
            r_mag2  <= r_mag1;
            r_last2 <= r_last1;
            r_sel3  <= n_sel;
            r_mag3  <= r_mag2;
            r_last3 <= r_last2;
        end
    end

    // Saturating add of a selected magnitude
    always_comb begin
        sum_wide = {1'b0, r_sum} + (EW + 1)'(r_sel3 ? r_mag3 : '0);
        n_sum    = sum_wide[EW] ? {EW{1'b1}} : sum_wide[EW-1:0];
    end

    // Running sum and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance && r_v3) begin
                r_sum <= r_last3 ? '0 : n_sum;
            end
            if (advance && r_v3 && r_last3) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_v3 && r_last3) begin
            r_out_data <= n_sum;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = hce_pkg::M_TDATA_W'(r_out_data);

endmodule

### rtl/core/hce_checker.sv
// Port-level checker for the harmonic comb energy block, bound to the top level.
`include "harmonic_comb_energy_macros.svh"

module hce_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [hce_pkg::M_TDATA_W-1:0]   o_m_tdata
);

    logic m_stall;

    assign m_stall = o_m_tvalid && !i_m_tready;

    // reset empties the output register
    `HCE_ASSERT_NEXT(a_reset_clears_out, i_clk, !i_rst_n, !o_m_tvalid)
    // a stalled energy item stays and holds its value
    `HCE_ASSERT_IMPLY(a_out_hold, i_clk, i_rst_n, $past(m_stall) && $past(i_rst_n),
                      o_m_tvalid && $stable(o_m_tdata))
    // input is never refused while the output side is free
    `HCE_ASSERT_IMPLY(a_ready_when_out_free, i_clk, i_rst_n, !o_m_tvalid, o_s_tready)
    // input is never refused while the output item is being taken
    `HCE_ASSERT_IMPLY(a_ready_when_draining, i_clk, i_rst_n,
                      o_m_tvalid && i_m_tready, o_s_tready)

endmodule

bind harmonic_comb_energy hce_checker u_hce_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

### tb/sv/hce_energy_checker.sv
// Checker for the harmonic comb energy block: predicts each frame energy and compares results.
module hce_energy_checker
    import hce_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    input  logic                    i_s_tready,
    input  logic [S_TDATA_W-1:0]    i_s_tdata,   // [23:0] magnitude
    input  logic                    i_s_tlast,   // last_bin
    input  logic                    i_m_tvalid,
    input  logic                    i_m_tready,
    input  logic [M_TDATA_W-1:0]    i_m_tdata,   // [34:0] energy, [39:35] zero
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output int                      o_fail_cnt,
    output int                      o_pending
);

    localparam int                    NUM_H      = DEF_NUM_HARMONICS;
    localparam int                    LAST_BIN   = DEF_MAX_BINS - 1;
    localparam logic [ENERGY_W-1:0]   ENERGY_TOP = {ENERGY_W{1'b1}};

    // shadow registers and frame state
    logic [FREQ_W-1:0]    fund_q8;
    logic [BINW_W-1:0]    binw_q8;
    logic [10:0]          bin_idx;
    logic [ENERGY_W-1:0]  energy_acc;
    logic [ENERGY_W-1:0]  energy_q[$];
    int                   n_fail;

    assign o_fail_cnt = n_fail;
    assign o_pending  = energy_q.size();

    initial n_fail = 0;

    // true when some harmonic falls in the closed interval around bin k (doubled scale)
    function automatic logic bin_in_comb(input logic [10:0] k);
        logic [63:0] center2;
        logic [63:0] harm2;
        logic        hit;
        center2 = 64'd2 * 64'(k) * 64'(binw_q8);
        hit     = 1'b0;
        for (int h = 1; h <= NUM_H; h++) begin
            harm2 = 64'd2 * 64'(h) * 64'(fund_q8);
            if (harm2 + 64'(binw_q8) >= center2 && harm2 <= center2 + 64'(binw_q8))
                hit = 1'b1;
        end
        return hit;
    endfunction

    always @(posedge i_clk) begin : mon
        logic [ENERGY_W:0]    sum_ext;
        logic [ENERGY_W-1:0]  want;
        logic [ENERGY_W-1:0]  got;
        logic [M_TDATA_W-ENERGY_W-1:0] pad;
        if (!i_rst_n) begin
            fund_q8    = '0;
            binw_q8    = '0;
            bin_idx    = '0;
            energy_acc = '0;
            energy_q.delete();
        end else begin
            // result side: compare against the oldest frame energy
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[ENERGY_W-1:0];
                pad = i_m_tdata[M_TDATA_W-1:ENERGY_W];
                if (energy_q.size() == 0) begin
                    $error("energy item with none expected, actual %0d", got);
                    n_fail++;
                end else begin
                    want = energy_q.pop_front();
                    if (got !== want) begin
                        $error("energy mismatch: expected %0d, actual %0d", want, got);
                        n_fail++;
                    end
                    if (pad !== '0) begin
                        $error("energy pad mismatch: expected 0, actual %0d", pad);
                        n_fail++;
                    end
                end
            end
            // bin side: accumulate selected magnitudes, close the frame on last
            if (i_s_tvalid && i_s_tready) begin
                if (bin_in_comb(bin_idx)) begin
                    sum_ext    = {1'b0, energy_acc} + (ENERGY_W+1)'(i_s_tdata[MAG_W-1:0]);
                    energy_acc = (sum_ext > {1'b0, ENERGY_TOP}) ? ENERGY_TOP
                                                                : sum_ext[ENERGY_W-1:0];
                end
                if (i_s_tlast) begin
                    energy_q.push_back(energy_acc);
                    energy_acc = '0;
                    bin_idx    = '0;
                end else if (int'(bin_idx) < LAST_BIN) begin
                    bin_idx = bin_idx + 11'd1;
                end
            end
            // register writes apply from the next bin on
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FUND: fund_q8 = i_cfg_data[FREQ_W-1:0];
                    CFG_BINW: binw_q8 = i_cfg_data[BINW_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

### tb/sv/tb_harmonic_comb_energy.sv
// Testbench top for the harmonic comb energy block: clock, reset, stimulus and verdict.
module tb_harmonic_comb_energy;
    import hce_pkg::*;

    localparam int          WATCHDOG  = 4000;
    localparam int          HOLD_LEN  = 400;
    localparam int          SETTLE    = 8;
    localparam longint      FUND_MAX  = 6144000;
    localparam longint      BINW_MAX  = 12288000;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [S_TDATA_W-1:0]   i_s_tdata  = '0;   // [23:0] magnitude
    logic                   i_s_tlast  = 1'b0; // last_bin
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   o_m_tdata;         // [34:0] energy, [39:35] zero
    logic                   i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    int                     fail_cnt;
    int                     pending;
    int                     idle_pct   = 0;
    int                     stall_pct  = 0;
    logic                   hold_req   = 1'b0;
    int                     hold_left  = 0;
    int                     quiet_cnt  = 0;
    int                     frames_done = 0;

    always #5 i_clk = ~i_clk;

    harmonic_comb_energy u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    hce_energy_checker u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req)
            hold_left = HOLD_LEN;
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cnt = 0;
        else
            quiet_cnt++;
        if (quiet_cnt >= WATCHDOG) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [MAG_W-1:0] pick_mag();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return {MAG_W{1'b1}};
        else if (r < 13)
            return '0;
        return MAG_W'($urandom);
    endfunction

    // one bin, after an optional random gap; returns at the acceptance edge
    task automatic send_bin(input logic [MAG_W-1:0] mag, input logic last);
        if ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= mag;
        i_s_tlast  <= last;
        do @(negedge i_clk); while (!o_s_tready);
        @(posedge i_clk);
        if (last)
            frames_done++;
    endtask

    task automatic send_frame(input int len, input logic closed);
        for (int i = 0; i < len; i++)
            send_bin(pick_mag(), closed && (i == len - 1));
    endtask

    // stop sending, wait for all energies, then let the pipeline drain
    task automatic wait_quiet();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_regs(input longint fund, input longint binw);
        wait_quiet();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FUND;
        i_cfg_data <= CFG_DATA_W'(fund);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_BINW;
        i_cfg_data <= CFG_DATA_W'(binw);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // random setting; mostly a fundamental near the bin width so low bins get hits
    task automatic set_random_regs();
        longint fund;
        longint binw;
        int     r;
        r = $urandom_range(9);
        case (r)
            0: begin
                fund = 0;
                binw = $urandom_range(BINW_MAX);
            end
            1: begin
                fund = $urandom_range(FUND_MAX);
                binw = 0;
            end
            2: begin
                fund = FUND_MAX;
                binw = BINW_MAX;
            end
            default: begin
                binw = $urandom_range(1, 1 << $urandom_range(4, 23));
                fund = (binw * $urandom_range(1, 9)) / $urandom_range(1, 4);
                if (fund > FUND_MAX)
                    fund = FUND_MAX;
            end
        endcase
        set_regs(fund, binw);
    endtask

    initial begin : stim
        int phase;
        int phase_items;
        int len;
        phase = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting: zero fundamental and zero width, every bin selected
        send_bin({MAG_W{1'b1}}, 1'b0);
        send_bin(24'h000001, 1'b0);
        send_bin(24'hABCDEF, 1'b1);
        // harmonic exactly on the edge between bins 0 and 1
        set_regs(256, 512);
        send_bin(24'h555555, 1'b0);
        send_bin(24'hAAAAAA, 1'b0);
        send_bin(24'h123456, 1'b0);
        send_bin(24'h0F0F0F, 1'b0);
        send_bin(24'hF0F0F0, 1'b1);
        // zero width with a nonzero fundamental: nothing selected
        set_regs(FUND_MAX, 0);
        send_bin({MAG_W{1'b1}}, 1'b0);
        send_bin(24'h7FFFFF, 1'b0);
        send_bin(24'h800000, 1'b1);
        // zero fundamental: only bin 0
        set_regs(0, BINW_MAX);
        send_bin(24'h000100, 1'b0);
        send_bin({MAG_W{1'b1}}, 1'b0);
        send_bin(24'h00FF00, 1'b0);
        send_bin(24'h000000, 1'b1);
        // both at their maximum
        set_regs(FUND_MAX, BINW_MAX);
        send_bin(24'hC3C3C3, 1'b0);
        send_bin(24'h3C3C3C, 1'b0);
        send_bin({MAG_W{1'b1}}, 1'b0);
        send_bin(24'h654321, 1'b1);
        // single-bin frames
        send_bin(24'h555555, 1'b1);
        send_bin(24'hAAAAAA, 1'b1);

        // random phases, cycling through the idling modes
        while (phase < 8 || frames_done < 40) begin
            // every bin selected in the second phase
            if (phase == 1)
                set_regs(0, 0);
            else
                set_random_regs();
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 56; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 56; end
                default: begin idle_pct = 30; stall_pct <= 30; end
            endcase
            if (phase == 2) begin
                hold_req <= 1'b1;
                @(posedge i_clk);
                hold_req <= 1'b0;
            end
            phase_items = 0;
            while (phase_items < 110) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(41, 120)
                                               : $urandom_range(1, 40);
                send_frame(len, 1'b1);
                phase_items += len;
            end
            // broken frame left open across the register write
            if ($urandom_range(9) < 3)
                send_frame($urandom_range(1, 30), 1'b0);
            phase++;
        end

        // close any open frame, then drain
        send_bin(pick_mag(), 1'b1);
        wait_quiet();
        if (fail_cnt == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
